>>> rtl/core/ddo_pkg.sv
package ddo_pkg;

  localparam int TRIG_BITS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int MUL_AW = 66;
  localparam int MUL_BW = 33;
  localparam logic [33:0] CORDIC_X0 = 34'd652032874;

  localparam logic [31:0] LEFT_CM_RST = 32'd1585431;
  localparam logic [31:0] RIGHT_CM_RST = 32'd1580613;
  localparam logic [31:0] TURN_GAIN_RST = 32'd56168033;
  localparam logic [31:0] RPM_RST = 32'd460175067;

  typedef enum logic [1:0] {
    REG_LEFT_CM  = 2'd0,
    REG_RIGHT_CM = 2'd1,
    REG_TURN     = 2'd2,
    REG_RPM      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_DL   = 3'd0,
    OP_DR   = 3'd1,
    OP_STEP = 3'd2,
    OP_LRPM = 3'd3,
    OP_RRPM = 3'd4,
    OP_X    = 3'd5,
    OP_Y    = 3'd6
  } op_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    logic cordic_go;
    logic emit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic cordic_done;
    logic out_busy;
  } status_t;

  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933405;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/ddo_if.sv
interface ddo_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_count;
  logic [31:0] right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddo_result_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] left_delta;
  logic signed [31:0] right_delta;
  logic signed [31:0] left_rpm;
  logic signed [31:0] right_rpm;
  logic signed [31:0] heading;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  modport source (output valid, left_delta, right_delta, left_rpm, right_rpm, heading,
                  pos_x_out, pos_y_out, input ready);
  modport sink (input valid, left_delta, right_delta, left_rpm, right_rpm, heading,
                pos_x_out, pos_y_out, output ready);
endinterface

>>> rtl/core/ddo_ctrl.sv
module ddo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ddo_pkg::status_t status,
  output ddo_pkg::cmd_t    cmd
);
  import ddo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MGO, S_MWAIT, S_CGO, S_CWAIT, S_EMIT
  } state_t;

  state_t state;
  op_t    op;

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.load      = in_ready && in_valid;
    cmd.mul_go    = (state == S_MGO);
    cmd.cordic_go = (state == S_CGO);
    cmd.emit      = (state == S_EMIT) && !status.out_busy;
    cmd.op        = op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_DL;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_MGO;
          op    <= OP_DL;
        end
        S_MGO: state <= S_MWAIT;
        S_MWAIT: if (status.mul_done) begin
          if (op == OP_RRPM) begin
            state <= S_CGO;
          end else if (op == OP_Y) begin
            state <= S_EMIT;
          end else begin
            state <= S_MGO;
            op    <= op_t'(op + 3'd1);
          end
        end
        S_CGO: state <= S_CWAIT;
        S_CWAIT: if (status.cordic_done) begin
          state <= S_MGO;
          op    <= OP_X;
        end
        S_EMIT: if (!status.out_busy) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/ddo_dp.sv
module ddo_dp #(
  parameter int TRIG_BITS = ddo_pkg::TRIG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ddo_pkg::cmd_t    cmd,
  output ddo_pkg::status_t status,
  input  logic [15:0]      left_count,
  input  logic [31:0]      right_count,
  input  logic [31:0]      left_cm,
  input  logic [31:0]      right_cm,
  input  logic [31:0]      turn_gain,
  input  logic [31:0]      rpm_gain,
  ddo_result_if.source     result
);
  import ddo_pkg::*;

  localparam int NITER = (TRIG_BITS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_BITS;

  logic [15:0]        prev_left;
  logic [31:0]        prev_right;
  logic [31:0]        angle;
  logic [31:0]        x_acc;
  logic [31:0]        y_acc;
  logic signed [16:0] dleft;
  logic signed [31:0] dright;
  logic signed [47:0] dl;
  logic signed [47:0] dr;
  logic signed [31:0] lrpm;
  logic signed [31:0] rrpm;
  logic signed [15:0] sn;
  logic signed [15:0] cs;

  logic [15:0] d16;
  logic [31:0] d32;
  always_comb begin
    d16 = left_count - prev_left;
    d32 = right_count - prev_right;
  end

  logic signed [MUL_AW-1:0] acc;
  logic signed [MUL_AW-1:0] a_sh;
  logic signed [MUL_BW-1:0] b_sh;
  logic [5:0]               mcnt;
  logic                     mbusy;
  logic                     mdone;

  logic signed [MUL_AW-1:0] a_sel;
  logic signed [MUL_BW-1:0] b_sel;
  logic signed [47:0]       dc;
  logic signed [48:0]       ddiff;

  always_comb begin
    dc    = 48'((49'(dl) + 49'(dr)) >>> 1);
    ddiff = 49'(dl) - 49'(dr);
    case (cmd.op)
      OP_DL: begin
        a_sel = MUL_AW'(dleft);
        b_sel = {1'b0, left_cm};
      end
      OP_DR: begin
        a_sel = MUL_AW'(dright);
        b_sel = {1'b0, right_cm};
      end
      OP_STEP: begin
        a_sel = MUL_AW'(ddiff);
        b_sel = {1'b0, turn_gain};
      end
      OP_LRPM: begin
        a_sel = MUL_AW'(dleft);
        b_sel = {1'b0, rpm_gain};
      end
      OP_RRPM: begin
        a_sel = MUL_AW'(dright);
        b_sel = {1'b0, rpm_gain};
      end
      OP_X: begin
        a_sel = MUL_AW'(dc);
        b_sel = MUL_BW'(sn);
      end
      OP_Y: begin
        a_sel = MUL_AW'(dc);
        b_sel = MUL_BW'(cs);
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  logic signed [MUL_AW-1:0] addend;
  always_comb begin
    if (!b_sh[0]) begin
      addend = '0;
    end else if (mcnt == 6'(MUL_BW - 1)) begin
      addend = -a_sh;
    end else begin
      addend = a_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_go) begin
        mbusy <= 1'b1;
      end else if (mbusy && mcnt == 6'(MUL_BW - 1)) begin
        mbusy <= 1'b0;
        mdone <= 1'b1;
      end
    end
    if (cmd.mul_go) begin
      acc  <= '0;
      a_sh <= a_sel;
      b_sh <= b_sel;
      mcnt <= '0;
    end else if (mbusy) begin
      acc  <= acc + addend;
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >>> 1;
      mcnt <= mcnt + 6'd1;
    end
  end

  logic signed [MUL_AW-1:0] r16;
  logic signed [MUL_AW-1:0] r15;
  logic signed [MUL_AW-1:0] rnd16;
  logic signed [31:0]       sat16;
  always_comb begin
    r16   = acc + MUL_AW'(32768);
    r15   = acc + MUL_AW'(16384);
    rnd16 = r16 >>> 16;
    if (rnd16 > MUL_AW'(64'sh7FFF_FFFF)) begin
      sat16 = 32'sh7FFF_FFFF;
    end else if (rnd16 < -MUL_AW'(64'sh8000_0000)) begin
      sat16 = 32'sh8000_0000;
    end else begin
      sat16 = rnd16[31:0];
    end
  end

  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [33:0] cz;
  logic               flip;
  logic [4:0]         ccnt;
  logic               cbusy;
  logic               cdone;
  logic [31:0]        a_rot;
  logic [31:0]        a_flip;
  logic signed [33:0] dxs;
  logic signed [33:0] dys;
  logic signed [33:0] atn;

  always_comb begin
    a_rot  = angle + 32'h4000_0000;
    a_flip = a_rot[31] ? angle + 32'h8000_0000 : angle;
    dxs    = cy >>> ccnt;
    dys    = cx >>> ccnt;
    atn    = 34'(atan_val(ccnt));
  end

  function automatic logic signed [15:0] trig_q15(input logic signed [33:0] v,
                                                  input logic neg);
    logic signed [33:0] r;
    logic signed [33:0] n;
    r = (v + 34'sd16384) >>> 15;
    n = neg ? -r : r;
    if (n > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (n < -34'sd32768) begin
      return 16'sh8000;
    end
    return n[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      cdone <= 1'b0;
    end else begin
      cdone <= 1'b0;
      if (cmd.cordic_go) begin
        cbusy <= 1'b1;
      end else if (cbusy && ccnt == 5'(NITER - 1)) begin
        cbusy <= 1'b0;
        cdone <= 1'b1;
      end
    end
    if (cmd.cordic_go) begin
      cx   <= CORDIC_X0;
      cy   <= '0;
      cz   <= 34'($signed(a_flip));
      flip <= a_rot[31];
      ccnt <= '0;
    end else if (cbusy) begin
      if (!cz[33]) begin
        cx <= cx - dxs;
        cy <= cy + dys;
        cz <= cz - atn;
      end else begin
        cx <= cx + dxs;
        cy <= cy - dys;
        cz <= cz + atn;
      end
      ccnt <= ccnt + 5'd1;
    end
    if (cdone) begin
      sn <= trig_q15(cy, flip);
      cs <= trig_q15(cx, flip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left    <= '0;
      prev_right   <= '0;
      angle        <= '0;
      x_acc        <= '0;
      y_acc        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        prev_left  <= left_count;
        prev_right <= right_count;
        dleft      <= -$signed({d16[15], d16});
        dright     <= $signed(d32);
      end
      if (mdone) begin
        case (cmd.op)
          OP_DL: dl <= rnd16[47:0];
          OP_DR: dr <= rnd16[47:0];
          OP_STEP: angle <= angle + r16[47:16];
          OP_LRPM: lrpm <= sat16;
          OP_RRPM: rrpm <= sat16;
          OP_X: x_acc <= x_acc + r15[46:15];
          OP_Y: y_acc <= y_acc + r15[46:15];
          default: ;
        endcase
      end
      if (cmd.emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
    if (cmd.emit) begin
      result.left_delta  <= dleft;
      result.right_delta <= dright;
      result.left_rpm    <= lrpm;
      result.right_rpm   <= rrpm;
      result.heading     <= $signed(angle);
      result.pos_x_out   <= $signed(x_acc);
      result.pos_y_out   <= $signed(y_acc);
    end
  end

  always_comb begin
    status.mul_done    = mdone;
    status.cordic_done = cdone;
    status.out_busy    = result.valid && !result.ready;
  end

endmodule

>>> rtl/core/differential_drive_odometry.sv
// Dead-reckoning odometry for a differential-drive base.
// The sample channel carries one beat per tick with the raw 16-bit left and
// 32-bit right quadrature counter readings. The result channel returns one
// beat per sample with the wheel deltas, the wheel speeds in rpm, the heading
// as a binary angle and the x and y position in Q16.16 cm.
// The four gains are written over the APB port; the user must write them only
// while the block is idle, as the block itself does not enforce it. Writes
// complete without wait states and reads return the stored values.
// One sample is processed at a time. A shared shift-add multiplier handles
// seven products one after another, and the CORDIC takes TRIG_BITS
// iterations, at most 24. The next sample is accepted only once the result of
// the last one has been loaded into the output register.
// Reset clears the previous readings, the heading and the position, and
// loads the default gains.
// The result is held in an output register. If the receiver stalls, the
// block still accepts and processes the next sample and waits with it until
// the held result has been taken.
module differential_drive_odometry #(
  parameter int TRIG_BITS = ddo_pkg::TRIG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ddo_sample_if.sink  sample,
  ddo_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ddo_pkg::*;

  logic [31:0] left_cm;
  logic [31:0] right_cm;
  logic [31:0] turn_gain;
  logic [31:0] rpm_gain;
  reg_idx_t    ridx;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cm   <= LEFT_CM_RST;
      right_cm  <= RIGHT_CM_RST;
      turn_gain <= TURN_GAIN_RST;
      rpm_gain  <= RPM_RST;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_LEFT_CM: left_cm <= pwdata;
        REG_RIGHT_CM: right_cm <= pwdata;
        REG_TURN: turn_gain <= pwdata;
        REG_RPM: rpm_gain <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_LEFT_CM: prdata = left_cm;
      REG_RIGHT_CM: prdata = right_cm;
      REG_TURN: prdata = turn_gain;
      REG_RPM: prdata = rpm_gain;
      default: prdata = '0;
    endcase
  end

  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ddo_dp #(
    .TRIG_BITS (TRIG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .left_count  (sample.left_count),
    .right_count (sample.right_count),
    .left_cm     (left_cm),
    .right_cm    (right_cm),
    .turn_gain   (turn_gain),
    .rpm_gain    (rpm_gain),
    .result      (result)
  );

endmodule

>>> rtl/core/ddo_checker.sv
module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_valid,
  input logic        s_ready,
  input logic        r_valid,
  input logic        r_ready,
  input logic [31:0] r_heading,
  input logic        pready
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_heading))
    else $error("result beat dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready |=> !s_ready)
    else $error("sample accepted while another is in work");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk       (clk),
  .rst       (rst),
  .s_valid   (sample.valid),
  .s_ready   (sample.ready),
  .r_valid   (result.valid),
  .r_ready   (result.ready),
  .r_heading (result.heading),
  .pready    (pready)
);
